### rtl/multi_resolution_context_window_top_assert.svh
// Assertion macros for the multi-resolution context window.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MULTI_RESOLUTION_CONTEXT_WINDOW_TOP_ASSERT_SVH
`define MULTI_RESOLUTION_CONTEXT_WINDOW_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define MRCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle that implies another condition in the next cycle.
`define MRCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MRCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mrcw_pkg.sv
// Package of the multi-resolution context window: sizes, types and control structs.
// Used by the top, lane, sequencer and merge modules of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mrcw_pkg;

  // Geometry of the window.
  localparam int FEATURES     = 8;
  localparam int FINE_SLOTS   = 4;
  localparam int MID_SLOTS    = 4;
  localparam int MID_SPAN     = 2;
  localparam int COARSE_SLOTS = 4;
  localparam int COARSE_SPAN  = 4;

  localparam int BLOCKS   = FINE_SLOTS + MID_SLOTS * MID_SPAN + COARSE_SLOTS * COARSE_SPAN;
  localparam int NSLOTS   = FINE_SLOTS + MID_SLOTS + COARSE_SLOTS;
  localparam int MAX_SPAN = (MID_SPAN > COARSE_SPAN) ? MID_SPAN : COARSE_SPAN;

  // Spans are powers of two, so a floored mean is an arithmetic shift.
  localparam int MID_SHIFT    = $clog2(MID_SPAN);
  localparam int COARSE_SHIFT = $clog2(COARSE_SPAN);

  localparam int DATA_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int PTR_W   = $clog2(BLOCKS);
  localparam int CNT_W   = $clog2(MAX_SPAN + 1);
  localparam int SHIFT_W = $clog2($clog2(MAX_SPAN) + 1);
  localparam int SUM_W   = DATA_W + $clog2(MAX_SPAN);

  // Mode codes of an input beat.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } state_t;

  // Control shared by all feature lanes.
  typedef struct packed {
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               dv;
    logic               first;
    logic [SHIFT_W-1:0] shift;
  } lane_ctl_t;

  // Control of the merging output stage.
  typedef struct packed {
    logic load;
    logic use_lanes;
    logic ready_res;
  } merge_ctl_t;

endpackage
`default_nettype wire

### rtl/mrcw_if.sv
// Valid/ready channel interfaces of the multi-resolution context window.
// Input beat carries mode, slot and eight features; result beat carries ready_res and eight values.
`timescale 1ns / 1ps
`default_nettype none
interface mrcw_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [3:0]         slot;
  logic signed [15:0] feat_0;
  logic signed [15:0] feat_1;
  logic signed [15:0] feat_2;
  logic signed [15:0] feat_3;
  logic signed [15:0] feat_4;
  logic signed [15:0] feat_5;
  logic signed [15:0] feat_6;
  logic signed [15:0] feat_7;

  modport source (output valid, mode, slot, feat_0, feat_1, feat_2, feat_3,
                  feat_4, feat_5, feat_6, feat_7, input ready);
  modport sink   (input valid, mode, slot, feat_0, feat_1, feat_2, feat_3,
                  feat_4, feat_5, feat_6, feat_7, output ready);
endinterface

interface mrcw_out_if;
  logic               valid;
  logic               ready;
  logic               ready_res;
  logic signed [15:0] val_0;
  logic signed [15:0] val_1;
  logic signed [15:0] val_2;
  logic signed [15:0] val_3;
  logic signed [15:0] val_4;
  logic signed [15:0] val_5;
  logic signed [15:0] val_6;
  logic signed [15:0] val_7;

  modport source (output valid, ready_res, val_0, val_1, val_2, val_3,
                  val_4, val_5, val_6, val_7, input ready);
  modport sink   (input valid, ready_res, val_0, val_1, val_2, val_3,
                  val_4, val_5, val_6, val_7, output ready);
endinterface
`default_nettype wire

### rtl/multi_resolution_context_window_top.sv
// Top level of the multi-resolution context window: sequencer, eight feature lanes, merge.
// Depends on mrcw_pkg, mrcw_if, mrcw_ctrl, mrcw_lane and mrcw_merge.
//
// Usage: in_ch carries beats of mode, slot and eight Q8.8 features; out_ch returns one
// beat per input beat with ready_res and eight Q8.8 values. Both use valid/ready.
// A push beat (mode 0) writes one block into a 28-deep ring; its result carries
// ready_res (ring full after this push) and zero values, registered in the output stage.
// A read beat (mode 1) returns one of 12 slots: four newest blocks, four means of two
// and four means of four older blocks, floored. Once the ring is full, a slot read
// walks its blocks through each lane's single memory read port, one block a cycle,
// and its result is loaded when the walk ends; no new beat is taken during the walk.
// Pushes, reads before the ring is full and slots of 12 or more load their result
// directly from the idle state, without a walk.
// A new beat is taken while the previous result waits, provided that result is being
// taken in the same cycle; otherwise in_ch.ready stays low while out_ch stalls.
// Reset (rst_n low, synchronous) empties the ring and the output register; the ring
// memory itself is not cleared, since no entry is read before it has been written.
`timescale 1ns / 1ps
`default_nettype none
module multi_resolution_context_window_top
  import mrcw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mrcw_in_if.sink    in_ch,
  mrcw_out_if.source out_ch
);

  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;
  logic       out_free;
  sample_t    feat [FEATURES];
  sample_t    lane_mean [FEATURES];

  // Features of the input beat, one per lane.
  assign feat[0] = in_ch.feat_0;
  assign feat[1] = in_ch.feat_1;
  assign feat[2] = in_ch.feat_2;
  assign feat[3] = in_ch.feat_3;
  assign feat[4] = in_ch.feat_4;
  assign feat[5] = in_ch.feat_5;
  assign feat[6] = in_ch.feat_6;
  assign feat[7] = in_ch.feat_7;

  // Sequencer.
  mrcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_slot   (in_ch.slot),
    .in_ready  (in_ch.ready),
    .out_free  (out_free),
    .lane_ctl  (lane_ctl),
    .merge_ctl (merge_ctl)
  );

  // Feature lanes working side by side.
  for (genvar g = 0; g < FEATURES; g++) begin : g_lane
    mrcw_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .wr_data (feat[g]),
      .mean    (lane_mean[g])
    );
  end

  // Result register.
  mrcw_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .lane_mean (lane_mean),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### rtl/mrcw_lane.sv
// One feature lane: a ring memory of one feature across all blocks, plus a mean accumulator.
// Depends on mrcw_pkg for sizes and the lane control struct.
`timescale 1ns / 1ps
`default_nettype none
module mrcw_lane
  import mrcw_pkg::*;
(
  input  wire logic      clk,
  input  wire lane_ctl_t ctl,
  input  wire sample_t   wr_data,
  output sample_t        mean
);

  sample_t                 mem [BLOCKS];
  sample_t                 rd_data_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_nxt;
  logic signed [SUM_W-1:0] scaled;

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  // Running sum; the first beat of a slot restarts it.
  always_comb begin
    if (ctl.first) begin
      acc_nxt = SUM_W'(rd_data_r);
    end else begin
      acc_nxt = acc_r + SUM_W'(rd_data_r);
    end
    scaled = acc_nxt >>> ctl.shift;
    mean   = scaled[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.dv) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/mrcw_ctrl.sv
// Sequencer of the context window: write pointer, fill count and the slot read walk.
// Depends on mrcw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_resolution_context_window_top_assert.svh"
module mrcw_ctrl
  import mrcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic                   in_ready,
  input  wire logic              out_free,
  output lane_ctl_t              lane_ctl,
  output merge_ctl_t             merge_ctl
);

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               issue_first_r, issue_first_nxt;
  logic               dv_r, first_r, last_r;

  logic               accept;
  logic               full;
  logic [PTR_W-1:0]   slot_w;
  logic [PTR_W-1:0]   age;
  logic [CNT_W-1:0]   span;
  logic [SHIFT_W-1:0] shift;
  logic [PTR_W:0]     ring_sum;
  logic [PTR_W-1:0]   start_addr;
  logic               issue_last;

  assign full     = (fill_r == PTR_W'(BLOCKS));
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Age of the newest block of the slot, its span and its mean shift.
  always_comb begin
    slot_w = PTR_W'(in_slot);
    if (in_slot < SLOT_W'(FINE_SLOTS)) begin
      age   = PTR_W'(FINE_SLOTS - 1) - slot_w;
      span  = CNT_W'(1);
      shift = '0;
    end else if (in_slot < SLOT_W'(FINE_SLOTS + MID_SLOTS)) begin
      age   = PTR_W'(FINE_SLOTS) + (slot_w - PTR_W'(FINE_SLOTS)) * PTR_W'(MID_SPAN);
      span  = CNT_W'(MID_SPAN);
      shift = SHIFT_W'(MID_SHIFT);
    end else begin
      age   = PTR_W'(FINE_SLOTS + MID_SLOTS * MID_SPAN)
            + (slot_w - PTR_W'(FINE_SLOTS + MID_SLOTS)) * PTR_W'(COARSE_SPAN);
      span  = CNT_W'(COARSE_SPAN);
      shift = SHIFT_W'(COARSE_SHIFT);
    end
    // Ring position of that block: one behind the write pointer, minus the age.
    ring_sum = {1'b0, wp_r} + (PTR_W+1)'(BLOCKS - 1) - {1'b0, age};
    if (ring_sum >= (PTR_W+1)'(BLOCKS)) begin
      start_addr = PTR_W'(ring_sum - (PTR_W+1)'(BLOCKS));
    end else begin
      start_addr = ring_sum[PTR_W-1:0];
    end
  end

  assign issue_last = (state_r == S_ISSUE) && (cnt_r == CNT_W'(1));

  // Next state and outputs.
  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    fill_nxt        = fill_r;
    rd_addr_nxt     = rd_addr_r;
    cnt_nxt         = cnt_r;
    shift_nxt       = shift_r;
    issue_first_nxt = issue_first_r;

    lane_ctl         = '0;
    lane_ctl.wr_addr = wp_r;
    lane_ctl.rd_addr = rd_addr_r;
    lane_ctl.dv      = dv_r;
    lane_ctl.first   = first_r;
    lane_ctl.shift   = shift_r;
    merge_ctl        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_PUSH) begin
            lane_ctl.wr_en = 1'b1;
            wp_nxt         = (wp_r == PTR_W'(BLOCKS - 1)) ? '0 : wp_r + 1'b1;
            fill_nxt       = full ? fill_r : fill_r + 1'b1;
            merge_ctl.load      = 1'b1;
            merge_ctl.ready_res = (fill_nxt == PTR_W'(BLOCKS));
          end else if (!full || (in_slot >= SLOT_W'(NSLOTS))) begin
            merge_ctl.load      = 1'b1;
            merge_ctl.ready_res = full;
          end else begin
            rd_addr_nxt     = start_addr;
            cnt_nxt         = span;
            shift_nxt       = shift;
            issue_first_nxt = 1'b1;
            state_nxt       = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        // One block of the slot a cycle, walking back in age.
        lane_ctl.rd_en  = 1'b1;
        rd_addr_nxt     = (rd_addr_r == '0) ? PTR_W'(BLOCKS - 1) : rd_addr_r - 1'b1;
        cnt_nxt         = cnt_r - 1'b1;
        issue_first_nxt = 1'b0;
        if (issue_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (last_r) begin
          merge_ctl.load      = 1'b1;
          merge_ctl.use_lanes = 1'b1;
          merge_ctl.ready_res = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wp_r          <= '0;
      fill_r        <= '0;
      cnt_r         <= '0;
      issue_first_r <= 1'b0;
      dv_r          <= 1'b0;
      first_r       <= 1'b0;
      last_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wp_r          <= wp_nxt;
      fill_r        <= fill_nxt;
      cnt_r         <= cnt_nxt;
      issue_first_r <= issue_first_nxt;
      dv_r          <= lane_ctl.rd_en;
      first_r       <= lane_ctl.rd_en && issue_first_r;
      last_r        <= issue_last;
    end
  end

  // Walk address and mean shift need no reset.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    shift_r   <= shift_nxt;
  end

  // A result is only loaded when the output stage can take it.
  `MRCW_ASSERT(a_load_free, clk, rst_n, merge_ctl.load |-> out_free, "result load into busy output")
  // Until the ring is full the write pointer tracks the fill count.
  `MRCW_ASSERT(a_wp_fill, clk, rst_n, (fill_r != PTR_W'(BLOCKS)) |-> (wp_r == fill_r), "write pointer lost fill")
  // A push always produces its result beat in the same cycle.
  `MRCW_ASSERT(a_push_result, clk, rst_n, lane_ctl.wr_en |-> (merge_ctl.load && !merge_ctl.use_lanes), "push without result")
  // The last read issued leads straight into the wait with the data flagged.
  `MRCW_ASSERT_NEXT(a_last_wait, clk, rst_n, issue_last, (last_r && dv_r && state_r == S_WAIT), "read walk ended badly")

endmodule
`default_nettype wire

### rtl/mrcw_merge.sv
// Merging output stage: collects the lane means or zeros into the registered result beat.
// Depends on mrcw_pkg and the result channel interface.
`timescale 1ns / 1ps
`default_nettype none
module mrcw_merge
  import mrcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire merge_ctl_t ctl,
  input  wire sample_t    lane_mean [FEATURES],
  output logic            out_free,
  mrcw_out_if.source      out_ch
);

  logic    valid_r;
  logic    ready_res_r;
  sample_t val_r [FEATURES];

  assign out_free = !valid_r || out_ch.ready;

  // Handshake state of the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: lane means for a slot read, zeros otherwise.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ready_res_r <= ctl.ready_res;
      for (int k = 0; k < FEATURES; k++) begin
        val_r[k] <= ctl.use_lanes ? lane_mean[k] : '0;
      end
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.ready_res = ready_res_r;
  assign out_ch.val_0     = val_r[0];
  assign out_ch.val_1     = val_r[1];
  assign out_ch.val_2     = val_r[2];
  assign out_ch.val_3     = val_r[3];
  assign out_ch.val_4     = val_r[4];
  assign out_ch.val_5     = val_r[5];
  assign out_ch.val_6     = val_r[6];
  assign out_ch.val_7     = val_r[7];

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the multi-resolution context window: a scoreboard class that
// predicts each result beat from the pushed blocks, plus tasks that drive both channels.
// Depends on mrcw_pkg, mrcw_if and multi_resolution_context_window_top.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import mrcw_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 240;
  localparam int HOLD_AFTER   = 300;
  localparam int RANDOM_BEATS = 1100;
  localparam int DRAIN_CYCLES = 20;

  // One input beat and one result beat, as the predictor sees them.
  typedef struct packed {
    logic                         mode;
    logic [SLOT_W-1:0]            slot;
    logic [FEATURES-1:0][DATA_W-1:0] feat;
  } window_beat_t;

  typedef struct packed {
    logic                         ready_res;
    logic [FEATURES-1:0][DATA_W-1:0] val;
  } window_result_t;

  // Predicts the window contents and checks result beats in order.
  class window_scoreboard;
    sample_t        ring [BLOCKS][FEATURES];
    int unsigned    head_ptr;
    int unsigned    fill_level;
    window_result_t expected_windows [$];
    int unsigned    mismatches;
    int unsigned    results_checked;
    int unsigned    pushes;
    int unsigned    reads;
    int unsigned    full_reads;
    int unsigned    wild_reads;

    function new();
      head_ptr        = 0;
      fill_level      = 0;
      mismatches      = 0;
      results_checked = 0;
      pushes          = 0;
      reads           = 0;
      full_reads      = 0;
      wild_reads      = 0;
    endfunction

    // Block of the given age, where age 0 is the newest block.
    function sample_t aged_sample(int age, int k);
      return ring[(head_ptr + 2 * BLOCKS - 1 - age) % BLOCKS][k];
    endfunction

    // Mean of span blocks starting at the given age, rounded toward minus infinity.
    function sample_t floored_mean(int age, int span, int k);
      int total;
      int q;
      total = 0;
      for (int a = 0; a < span; a++) total += int'(aged_sample(age + a, k));
      if (total >= 0) q = total / span;
      else q = -((-total + span - 1) / span);
      return sample_t'(q);
    endfunction

    function window_result_t compute_window(window_beat_t b);
      window_result_t r;
      int s;
      int age;
      int span;
      r = '0;
      s = int'(b.slot);
      if (b.mode == MODE_PUSH) begin
        for (int k = 0; k < FEATURES; k++) ring[head_ptr][k] = sample_t'(b.feat[k]);
        head_ptr = (head_ptr + 1) % BLOCKS;
        if (fill_level < BLOCKS) fill_level++;
        r.ready_res = (fill_level >= BLOCKS);
        return r;
      end
      r.ready_res = (fill_level >= BLOCKS);
      if (!r.ready_res || s >= NSLOTS) return r;
      if (s < FINE_SLOTS) begin
        age  = FINE_SLOTS - 1 - s;
        span = 1;
      end else if (s < FINE_SLOTS + MID_SLOTS) begin
        age  = FINE_SLOTS + (s - FINE_SLOTS) * MID_SPAN;
        span = MID_SPAN;
      end else begin
        age  = FINE_SLOTS + MID_SLOTS * MID_SPAN + (s - FINE_SLOTS - MID_SLOTS) * COARSE_SPAN;
        span = COARSE_SPAN;
      end
      for (int k = 0; k < FEATURES; k++) r.val[k] = floored_mean(age, span, k);
      return r;
    endfunction

    // Called for every input beat taken by the block.
    function void note_input(window_beat_t b);
      if (b.mode == MODE_PUSH) begin
        pushes++;
      end else begin
        reads++;
        if (fill_level >= BLOCKS) full_reads++;
        if (int'(b.slot) >= NSLOTS) wild_reads++;
      end
      expected_windows.push_back(compute_window(b));
    endfunction

    // Called for every result beat taken from the block.
    function void check_result(window_result_t got);
      window_result_t want;
      results_checked++;
      if (expected_windows.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: ready_res %0b", $time,
                 got.ready_res);
        return;
      end
      want = expected_windows.pop_front();
      if (got.ready_res !== want.ready_res) begin
        mismatches++;
        $display("%0t: ready_res expected %0b, got %0b", $time, want.ready_res,
                 got.ready_res);
      end
      for (int k = 0; k < FEATURES; k++) begin
        if (got.val[k] !== want.val[k]) begin
          mismatches++;
          $display("%0t: val_%0d expected %0d, got %0d", $time, k,
                   $signed(want.val[k]), $signed(got.val[k]));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_windows.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mrcw_in_if  in_ch ();
  mrcw_out_if out_ch ();

  multi_resolution_context_window_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  window_scoreboard sb = new();
  int unsigned      beats_offered = 0;

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Sender idle gap: mostly none or short, a few long, and stretches of none at all.
  function automatic int sender_gap();
    int pick;
    if ((beats_offered % 200) < 50) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A feature value drawn from the extremes or from the whole range.
  function automatic sample_t random_sample(int flavour);
    int pick;
    case (flavour)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          default: return 16'sh8001;
        endcase
      end
      default: return sample_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // Offers one beat after a random gap and waits until the block takes it.
  task automatic offer_beat(input window_beat_t b);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.mode   = b.mode;
    in_ch.slot   = b.slot;
    in_ch.feat_0 = b.feat[0];
    in_ch.feat_1 = b.feat[1];
    in_ch.feat_2 = b.feat[2];
    in_ch.feat_3 = b.feat[3];
    in_ch.feat_4 = b.feat[4];
    in_ch.feat_5 = b.feat[5];
    in_ch.feat_6 = b.feat[6];
    in_ch.feat_7 = b.feat[7];
    in_ch.valid  = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b);
    beats_offered++;
  endtask

  task automatic offer_read(input int s);
    window_beat_t b;
    b      = '0;
    b.mode = MODE_READ;
    b.slot = s[SLOT_W-1:0];
    for (int k = 0; k < FEATURES; k++) b.feat[k] = sample_t'($urandom_range(0, 16'hffff));
    offer_beat(b);
  endtask

  // Stimulus: directed fill and slot sweep, then random traffic.
  initial begin
    window_beat_t b;
    int           flavour;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_PUSH;
    in_ch.slot   = '0;
    in_ch.feat_0 = '0;
    in_ch.feat_1 = '0;
    in_ch.feat_2 = '0;
    in_ch.feat_3 = '0;
    in_ch.feat_4 = '0;
    in_ch.feat_5 = '0;
    in_ch.feat_6 = '0;
    in_ch.feat_7 = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reads before the ring is full return zeros with ready_res low.
    offer_read(0);
    offer_read(15);

    // Fill the ring with extreme blocks, so that the means hit the limits of the
    // range and the floor of negative half values.
    for (int i = 0; i < BLOCKS; i++) begin
      b      = '0;
      b.mode = MODE_PUSH;
      b.slot = SLOT_W'(i % 16);
      for (int k = 0; k < FEATURES; k++) begin
        case (i % 4)
          0: b.feat[k] = 16'sh7fff;
          1: b.feat[k] = 16'sh8000;
          2: b.feat[k] = (k % 2) ? -16'sd1 : 16'sd0;
          default: b.feat[k] = (k % 2) ? 16'sd1 : sample_t'(16'sh8000 + k);
        endcase
      end
      offer_beat(b);
    end

    // Every slot once the ring is full, the out-of-range ones too.
    for (int s = 0; s < 16; s++) offer_read(s);

    // Random traffic: mostly well-formed reads and pushes, some wild slots.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      b = '0;
      if ($urandom_range(0, 99) < 35) begin
        b.mode  = MODE_PUSH;
        b.slot  = SLOT_W'($urandom_range(0, 15));
        flavour = $urandom_range(0, 9);
        if (flavour > 3) flavour = 3;
        for (int k = 0; k < FEATURES; k++) b.feat[k] = random_sample(flavour);
      end else begin
        b.mode = MODE_READ;
        if ($urandom_range(0, 99) < 88) b.slot = SLOT_W'($urandom_range(0, NSLOTS - 1));
        else b.slot = SLOT_W'($urandom_range(NSLOTS, 15));
        for (int k = 0; k < FEATURES; k++) b.feat[k] = sample_t'($urandom_range(0, 16'hffff));
      end
      offer_beat(b);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Drain, then allow a few cycles for any stray result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pushes and %0d reads (%0d with a full ring, %0d wild slots).",
             sb.pushes, sb.reads, sb.full_reads, sb.wild_reads);
    $display("Checked %0d result beats, %0d field mismatches, one long output hold.",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random stalls, and one long hold-off so that the block backs up.
  initial begin
    int  pick;
    int  run;
    bit  held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.results_checked >= HOLD_AFTER) begin
        held         = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ch.ready = 1'b1;
          run          = $urandom_range(1, 20);
        end else if (pick < 70) begin
          out_ch.ready = 1'b1;
          run          = $urandom_range(50, 100);
        end else if (pick < 95) begin
          out_ch.ready = 1'b0;
          run          = $urandom_range(1, 3);
        end else begin
          out_ch.ready = 1'b0;
          run          = $urandom_range(15, 40);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // Result monitor: every beat taken on the output goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    window_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ready_res = out_ch.ready_res;
      got.val       = {out_ch.val_7, out_ch.val_6, out_ch.val_5, out_ch.val_4,
                       out_ch.val_3, out_ch.val_2, out_ch.val_1, out_ch.val_0};
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin : stall_watchdog
    int unsigned quiet_cycles;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
`default_nettype wire
